>>> rtl/core/bsfh_pkg.sv
// Shared types for the Biot-Savart field Hessian unit: datapath commands,
// controller status and the default coordinate format. No dependencies.
`timescale 1ns / 1ps

package bsfh_pkg;

   localparam int DefaultFracBits = 24;

   // One datapath operation per cycle, issued by the controller.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_ZERO,
      OP_MAX,
      OP_NORM,
      OP_SQ,
      OP_SQRT,
      OP_DIV,
      OP_I2,
      OP_I4,
      OP_CRA,
      OP_CRB,
      OP_UU,
      OP_TA,
      OP_TB,
      OP_TC,
      OP_TM,
      OP_TP,
      OP_TS,
      OP_TW,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] sel;
      logic [5:0] cnt;
      logic [1:0] k1;
      logic [1:0] k2;
      logic [1:0] a;
      logic [3:0] row;
   } cmd_type;

   typedef struct packed {
      logic d_zero;
      logic last;
      logic out_free;
   } status_type;

endpackage

>>> rtl/core/bsfh_ctrl.sv
// Sequencer of the field Hessian unit: walks each item through normalize,
// square root, divisions, cross product and 27 term updates. Uses bsfh_pkg.
`timescale 1ns / 1ps

module bsfh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bsfh_pkg::status_type status,
   output bsfh_pkg::cmd_type   cmd
);
   import bsfh_pkg::*;

   typedef enum logic [16:0] {
      S_IDLE  = 17'b00000000000000001,
      S_MAX   = 17'b00000000000000010,
      S_NORM  = 17'b00000000000000100,
      S_SQ    = 17'b00000000000001000,
      S_SQRT  = 17'b00000000000010000,
      S_DIV   = 17'b00000000000100000,
      S_INV   = 17'b00000000001000000,
      S_CROSS = 17'b00000000010000000,
      S_UU    = 17'b00000000100000000,
      S_TA    = 17'b00000001000000000,
      S_TB    = 17'b00000010000000000,
      S_TC    = 17'b00000100000000000,
      S_TM    = 17'b00001000000000000,
      S_TP    = 17'b00010000000000000,
      S_TS    = 17'b00100000000000000,
      S_TW    = 17'b01000000000000000,
      S_EMIT  = 17'b10000000000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] sel_ff, sel_in;
   logic [1:0] k1_ff, k1_in;
   logic [1:0] k2_ff, k2_in;
   logic [1:0] a_ff, a_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      k1_in    = k1_ff;
      k2_in    = k2_ff;
      a_in     = a_ff;
      cmd.op   = OP_NONE;
      cmd.sel  = sel_ff;
      cmd.cnt  = cnt_ff;
      cmd.k1   = k1_ff;
      cmd.k2   = k2_ff;
      cmd.a    = a_ff;
      cmd.row  = (4'(k1_ff) << 1) + 4'(k1_ff) + 4'(k2_ff);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_MAX;
            end
         end
         S_MAX: begin
            k1_in  = 2'd0;
            k2_in  = 2'd0;
            a_in   = 2'd0;
            cnt_in = 6'd0;
            if (status.d_zero) begin
               cmd.op   = OP_ZERO;
               state_in = status.last ? S_EMIT : S_IDLE;
            end else begin
               cmd.op   = OP_MAX;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            cmd.op   = OP_NORM;
            cnt_in   = 6'd0;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.op  = OP_SQ;
            cmd.sel = cnt_ff[1:0];
            if (cnt_ff == 6'd2) begin
               cnt_in   = 6'd0;
               state_in = S_SQRT;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_SQRT: begin
            cmd.op = OP_SQRT;
            if (cnt_ff == 6'd31) begin
               cnt_in   = 6'd0;
               sel_in   = 2'd0;
               state_in = S_DIV;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            if (cnt_ff == 6'd32) begin
               cnt_in = 6'd0;
               if (sel_ff == 2'd3) begin
                  sel_in   = 2'd0;
                  state_in = S_INV;
               end else begin
                  sel_in = sel_ff + 2'd1;
               end
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_INV: begin
            cmd.op = (cnt_ff[0]) ? OP_I4 : OP_I2;
            if (cnt_ff == 6'd1) begin
               cnt_in   = 6'd0;
               state_in = S_CROSS;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_CROSS: begin
            cmd.op  = (cnt_ff[0]) ? OP_CRB : OP_CRA;
            cmd.sel = cnt_ff[2:1];
            if (cnt_ff == 6'd5) begin
               cnt_in   = 6'd0;
               state_in = S_UU;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_UU: begin
            cmd.op   = OP_UU;
            state_in = S_TA;
         end
         S_TA: begin
            cmd.op   = OP_TA;
            state_in = S_TB;
         end
         S_TB: begin
            cmd.op   = OP_TB;
            state_in = S_TC;
         end
         S_TC: begin
            cmd.op   = OP_TC;
            state_in = S_TM;
         end
         S_TM: begin
            cmd.op   = OP_TM;
            state_in = S_TP;
         end
         S_TP: begin
            cmd.op   = OP_TP;
            state_in = S_TS;
         end
         S_TS: begin
            cmd.op   = OP_TS;
            state_in = S_TW;
         end
         S_TW: begin
            cmd.op = OP_TW;
            if (a_ff == 2'd2) begin
               a_in = 2'd0;
               if (k2_ff == 2'd2) begin
                  k2_in = 2'd0;
                  if (k1_ff == 2'd2) begin
                     k1_in    = 2'd0;
                     state_in = status.last ? S_EMIT : S_IDLE;
                  end else begin
                     k1_in    = k1_ff + 2'd1;
                     state_in = S_UU;
                  end
               end else begin
                  k2_in    = k2_ff + 2'd1;
                  state_in = S_UU;
               end
            end else begin
               a_in     = a_ff + 2'd1;
               state_in = S_TA;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.op = OP_EMIT;
               if (k2_ff == 2'd2) begin
                  k2_in = 2'd0;
                  if (k1_ff == 2'd2) begin
                     k1_in    = 2'd0;
                     state_in = S_IDLE;
                  end else begin
                     k1_in = k1_ff + 2'd1;
                  end
               end else begin
                  k2_in = k2_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 6'd0;
         sel_ff   <= 2'd0;
         k1_ff    <= 2'd0;
         k2_ff    <= 2'd0;
         a_ff     <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
         k1_ff    <= k1_in;
         k2_ff    <= k2_in;
         a_ff     <= a_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_MAX))
      else $error("accepted beat did not start the normalize step");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff <= 6'd32))
      else $error("divider step count ran past its last step");

endmodule

>>> rtl/core/bsfh_datapath.sv
// Datapath of the field Hessian unit: shared multiplier, bit-serial square root
// and divider, term shifter and the 27 saturating accumulators. Uses bsfh_pkg.
`timescale 1ns / 1ps

module bsfh_datapath #(
   parameter int COORD_FRAC_BITS = bsfh_pkg::DefaultFracBits
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic signed [31:0]   req_point_x,
   input  logic signed [31:0]   req_point_y,
   input  logic signed [31:0]   req_point_z,
   input  logic signed [31:0]   req_curve_x,
   input  logic signed [31:0]   req_curve_y,
   input  logic signed [31:0]   req_curve_z,
   input  logic signed [31:0]   req_tangent_x,
   input  logic signed [31:0]   req_tangent_y,
   input  logic signed [31:0]   req_tangent_z,
   input  logic                 req_last_quad,
   input  bsfh_pkg::cmd_type    cmd,
   output bsfh_pkg::status_type status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_row_index,
   output logic [1:0]           rsp_col_index,
   output logic signed [63:0]   rsp_comp_x,
   output logic signed [63:0]   rsp_comp_y,
   output logic signed [63:0]   rsp_comp_z,
   output logic                 rsp_saturated,
   output logic                 rsp_last_entry
);
   import bsfh_pkg::*;

   localparam int ShiftOffset = 3 * COORD_FRAC_BITS - 119;
   localparam logic signed [63:0] SumMax = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] SumMin = {1'b1, 63'd0};

   function automatic logic [1:0] inc3(input logic [1:0] v);
      inc3 = (v == 2'd2) ? 2'd0 : v + 2'd1;
   endfunction

   // Index of the tangent component that survives T x e_k in component a.
   function automatic logic [1:0] other3(input logic [1:0] a, input logic [1:0] k);
      other3 = (a == k) ? 2'd0 : 2'd3 - a - k;
   endfunction

   function automatic logic signed [69:0] trunc30(input logic signed [69:0] v);
      logic signed [69:0] bias;
      bias    = v[69] ? 70'sh3FFFFFFF : 70'sd0;
      trunc30 = (v + bias) >>> 30;
   endfunction

   logic signed [32:0] d_ff [3], d_in [3];
   logic signed [31:0] t_ff [3], t_in [3];
   logic               last_ff, last_in;
   logic [31:0]        m_ff, m_in;
   logic signed [5:0]  e_ff, e_in;
   logic signed [32:0] dn_ff [3], dn_in [3];
   logic [63:0]        r2_ff, r2_in;
   logic [63:0]        res_ff, res_in;
   logic [31:0]        rem_ff, rem_in;
   logic [31:0]        lo_ff, lo_in;
   logic [31:0]        quo_ff, quo_in;
   logic signed [31:0] u_ff [3], u_in [3];
   logic [31:0]        i1_ff, i1_in;
   logic [31:0]        i2_ff, i2_in;
   logic [31:0]        i4_ff, i4_in;
   logic signed [69:0] crt_ff, crt_in;
   logic signed [33:0] c_ff [3], c_in [3];
   logic signed [31:0] uu_ff, uu_in;
   logic signed [32:0] pa_ff, pa_in;
   logic signed [32:0] pb_ff, pb_in;
   logic signed [33:0] pc_ff, pc_in;
   logic signed [39:0] bsum_ff, bsum_in;
   logic [71:0]        prod_ff, prod_in;
   logic               neg_ff, neg_in;
   logic signed [63:0] term_ff, term_in;
   logic signed [63:0] acc_ff [9][3], acc_in [9][3];
   logic [26:0]        valid_ff, valid_in;
   logic               sat_ff, sat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_row_ff, rsp_row_in;
   logic [1:0]         rsp_col_ff, rsp_col_in;
   logic signed [63:0] rsp_x_ff, rsp_x_in;
   logic signed [63:0] rsp_y_ff, rsp_y_in;
   logic signed [63:0] rsp_z_ff, rsp_z_in;
   logic               rsp_sat_ff, rsp_sat_in;
   logic               rsp_last_ff, rsp_last_in;

   logic signed [34:0] mul_a, mul_b;
   logic signed [69:0] mul_p, mul_tr, cr_tr;
   logic [31:0]        absd [3];
   logic [31:0]        mag_dn;
   logic [4:0]         top;
   logic signed [5:0]  e_new;
   logic [63:0]        bitv, rb;
   logic [61:0]        num;
   logic [32:0]        sh;
   logic [33:0]        trial;
   logic               ge;
   logic [31:0]        qn;
   logic [39:0]        bmag;
   logic [63:0]        p_lo;
   logic [39:0]        p_hi;
   logic signed [9:0]  s_val;
   logic [9:0]         nshift;
   logic [135:0]       wide;
   logic               big, tsat;
   logic [4:0]         idx, base;
   logic signed [63:0] old_v;
   logic signed [64:0] sum65;
   logic               ovf;

   assign status.d_zero   = (d_ff[0] == 33'sd0) && (d_ff[1] == 33'sd0) && (d_ff[2] == 33'sd0);
   assign status.last     = last_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // Shared multiplier operands.
   always_comb begin
      mul_a = 35'sd0;
      mul_b = 35'sd0;
      case (cmd.op)
         OP_SQ: begin
            mul_a = 35'(dn_ff[cmd.sel]);
            mul_b = 35'(dn_ff[cmd.sel]);
         end
         OP_I2: begin
            mul_a = {3'b000, i1_ff};
            mul_b = {3'b000, i1_ff};
         end
         OP_I4: begin
            mul_a = {3'b000, i2_ff};
            mul_b = {3'b000, i2_ff};
         end
         OP_CRA: begin
            mul_a = 35'(t_ff[inc3(cmd.sel)]);
            mul_b = 35'(u_ff[inc3(inc3(cmd.sel))]);
         end
         OP_CRB: begin
            mul_a = 35'(t_ff[inc3(inc3(cmd.sel))]);
            mul_b = 35'(u_ff[inc3(cmd.sel)]);
         end
         OP_UU: begin
            mul_a = 35'(u_ff[cmd.k1]);
            mul_b = 35'(u_ff[cmd.k2]);
         end
         OP_TA: begin
            mul_a = 35'(u_ff[cmd.k1]);
            mul_b = 35'(t_ff[other3(cmd.a, cmd.k2)]);
         end
         OP_TB: begin
            mul_a = 35'(u_ff[cmd.k2]);
            mul_b = 35'(t_ff[other3(cmd.a, cmd.k1)]);
         end
         OP_TC: begin
            mul_a = 35'(uu_ff);
            mul_b = 35'(c_ff[cmd.a]);
         end
         default: begin
            mul_a = 35'sd0;
            mul_b = 35'sd0;
         end
      endcase
   end

   assign mul_p  = mul_a * mul_b;
   assign mul_tr = trunc30(mul_p);
   assign cr_tr  = trunc30(crt_ff - mul_p);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         absd[i] = d_ff[i][32] ? 32'(-d_ff[i]) : d_ff[i][31:0];
      end
      top = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (m_ff[i]) top = 5'(i);
      end
      e_new  = 6'sd30 - $signed({1'b0, top});
      mag_dn = dn_ff[cmd.sel][32] ? 32'(-dn_ff[cmd.sel]) : dn_ff[cmd.sel][31:0];
      num    = (cmd.sel == 2'd3) ? {1'b1, 61'd0} : {mag_dn, 30'd0};
      bitv   = 64'd1 << (6'd62 - {cmd.cnt[4:0], 1'b0});
      rb     = res_ff + bitv;
      sh     = {rem_ff, lo_ff[31]};
      trial  = {1'b0, sh} - {2'b00, res_ff[31:0]};
      ge     = !trial[33];
      qn     = {quo_ff[30:0], ge};
      bmag   = bsum_ff[39] ? 40'(-bsum_ff) : 40'(bsum_ff);
      p_lo   = 64'(bmag[31:0]) * 64'(i4_ff);
      p_hi   = 40'(bmag[39:32]) * 40'(i4_ff);
      s_val  = ({{4{e_ff[5]}}, e_ff} <<< 2) + 10'(ShiftOffset);
      nshift = -s_val;
      big    = 1'b0;
      if (s_val < 10'sd0) begin
         wide = {64'd0, prod_ff} >> nshift;
      end else if (s_val < 10'sd64) begin
         wide = {64'd0, prod_ff} << s_val[5:0];
      end else begin
         wide = 136'd0;
         big  = (prod_ff != 72'd0);
      end
      tsat = big || (!neg_ff && (|wide[135:63])) ||
             (neg_ff && ((|wide[135:64]) || (wide[63] && (|wide[62:0]))));
      idx   = (5'(cmd.row) << 1) + 5'(cmd.row) + 5'(cmd.a);
      base  = (5'(cmd.row) << 1) + 5'(cmd.row);
      old_v = valid_ff[idx] ? acc_ff[cmd.row][cmd.a] : 64'sd0;
      sum65 = {old_v[63], old_v} + {term_ff[63], term_ff};
      ovf   = (sum65[64] != sum65[63]);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_in[i]  = d_ff[i];
         t_in[i]  = t_ff[i];
         dn_in[i] = dn_ff[i];
         u_in[i]  = u_ff[i];
         c_in[i]  = c_ff[i];
      end
      for (int r = 0; r < 9; r++) begin
         for (int j = 0; j < 3; j++) begin
            acc_in[r][j] = acc_ff[r][j];
         end
      end
      last_in      = last_ff;
      m_in         = m_ff;
      e_in         = e_ff;
      r2_in        = r2_ff;
      res_in       = res_ff;
      rem_in       = rem_ff;
      lo_in        = lo_ff;
      quo_in       = quo_ff;
      i1_in        = i1_ff;
      i2_in        = i2_ff;
      i4_in        = i4_ff;
      crt_in       = crt_ff;
      uu_in        = uu_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      pc_in        = pc_ff;
      bsum_in      = bsum_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      term_in      = term_ff;
      valid_in     = valid_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_last_in  = rsp_last_ff;
      case (cmd.op)
         OP_LOAD: begin
            d_in[0] = 33'(req_point_x) - 33'(req_curve_x);
            d_in[1] = 33'(req_point_y) - 33'(req_curve_y);
            d_in[2] = 33'(req_point_z) - 33'(req_curve_z);
            t_in[0] = req_tangent_x;
            t_in[1] = req_tangent_y;
            t_in[2] = req_tangent_z;
            last_in = req_last_quad;
         end
         OP_ZERO: begin
            sat_in = 1'b1;
         end
         OP_MAX: begin
            m_in = absd[0];
            if (absd[1] > m_in) m_in = absd[1];
            if (absd[2] > m_in) m_in = absd[2];
         end
         OP_NORM: begin
            e_in   = e_new;
            r2_in  = 64'd0;
            res_in = 64'd0;
            for (int i = 0; i < 3; i++) begin
               if (e_new >= 6'sd0) begin
                  dn_in[i] = d_ff[i] <<< e_new[4:0];
               end else begin
                  dn_in[i] = (d_ff[i] + $signed({32'd0, d_ff[i][32]})) >>> 1;
               end
            end
         end
         OP_SQ: begin
            r2_in = r2_ff + mul_p[63:0];
         end
         OP_SQRT: begin
            if (r2_ff >= rb) begin
               r2_in  = r2_ff - rb;
               res_in = (res_ff >> 1) + bitv;
            end else begin
               res_in = res_ff >> 1;
            end
         end
         OP_DIV: begin
            if (cmd.cnt == 6'd0) begin
               rem_in = {2'b00, num[61:32]};
               lo_in  = num[31:0];
               quo_in = 32'd0;
            end else begin
               rem_in = ge ? trial[31:0] : sh[31:0];
               lo_in  = {lo_ff[30:0], 1'b0};
               quo_in = qn;
               if (cmd.cnt == 6'd32) begin
                  if (cmd.sel == 2'd3) begin
                     i1_in = qn;
                  end else begin
                     u_in[cmd.sel] = dn_ff[cmd.sel][32] ? -$signed(qn) : $signed(qn);
                  end
               end
            end
         end
         OP_I2: begin
            i2_in = mul_p[62:31];
         end
         OP_I4: begin
            i4_in = mul_p[62:31];
         end
         OP_CRA: begin
            crt_in = mul_p;
         end
         OP_CRB: begin
            c_in[cmd.sel] = cr_tr[33:0];
         end
         OP_UU: begin
            uu_in = mul_tr[31:0];
         end
         OP_TA: begin
            if (cmd.a == cmd.k2) pa_in = 33'sd0;
            else if (cmd.k2 == inc3(inc3(cmd.a))) pa_in = mul_tr[32:0];
            else pa_in = -mul_tr[32:0];
         end
         OP_TB: begin
            if (cmd.a == cmd.k1) pb_in = 33'sd0;
            else if (cmd.k1 == inc3(inc3(cmd.a))) pb_in = mul_tr[32:0];
            else pb_in = -mul_tr[32:0];
         end
         OP_TC: begin
            pc_in = mul_tr[33:0];
         end
         OP_TM: begin
            bsum_in = 40'sd15 * 40'(pc_ff) - 40'sd3 * (40'(pa_ff) + 40'(pb_ff));
            if (cmd.k1 == cmd.k2) bsum_in = bsum_in - 40'sd3 * 40'(c_ff[cmd.a]);
         end
         OP_TP: begin
            prod_in = 72'(p_lo) + {p_hi, 32'd0};
            neg_in  = bsum_ff[39];
         end
         OP_TS: begin
            if (tsat) begin
               term_in = neg_ff ? SumMin : SumMax;
               sat_in  = 1'b1;
            end else begin
               term_in = neg_ff ? -$signed(wide[63:0]) : $signed(wide[63:0]);
            end
         end
         OP_TW: begin
            valid_in[idx] = 1'b1;
            if (ovf) begin
               acc_in[cmd.row][cmd.a] = sum65[64] ? SumMin : SumMax;
               sat_in = 1'b1;
            end else begin
               acc_in[cmd.row][cmd.a] = sum65[63:0];
            end
         end
         OP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_row_in   = cmd.k1;
            rsp_col_in   = cmd.k2;
            rsp_x_in     = valid_ff[base] ? acc_ff[cmd.row][0] : 64'sd0;
            rsp_y_in     = valid_ff[base + 5'd1] ? acc_ff[cmd.row][1] : 64'sd0;
            rsp_z_in     = valid_ff[base + 5'd2] ? acc_ff[cmd.row][2] : 64'sd0;
            rsp_sat_in   = sat_ff;
            rsp_last_in  = (cmd.k1 == 2'd2) && (cmd.k2 == 2'd2);
            valid_in[base]        = 1'b0;
            valid_in[base + 5'd1] = 1'b0;
            valid_in[base + 5'd2] = 1'b0;
            if ((cmd.k1 == 2'd2) && (cmd.k2 == 2'd2)) sat_in = 1'b0;
         end
         default: begin
            sat_in = sat_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 27'd0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         d_ff[i]  <= d_in[i];
         t_ff[i]  <= t_in[i];
         dn_ff[i] <= dn_in[i];
         u_ff[i]  <= u_in[i];
         c_ff[i]  <= c_in[i];
      end
      for (int r = 0; r < 9; r++) begin
         for (int j = 0; j < 3; j++) begin
            acc_ff[r][j] <= acc_in[r][j];
         end
      end
      last_ff     <= last_in;
      m_ff        <= m_in;
      e_ff        <= e_in;
      r2_ff       <= r2_in;
      res_ff      <= res_in;
      rem_ff      <= rem_in;
      lo_ff       <= lo_in;
      quo_ff      <= quo_in;
      i1_ff       <= i1_in;
      i2_ff       <= i2_in;
      i4_ff       <= i4_in;
      crt_ff      <= crt_in;
      uu_ff       <= uu_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      pc_ff       <= pc_in;
      bsum_ff     <= bsum_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      term_ff     <= term_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_sat_ff  <= rsp_sat_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_index  = rsp_row_ff;
   assign rsp_col_index  = rsp_col_ff;
   assign rsp_comp_x     = rsp_x_ff;
   assign rsp_comp_y     = rsp_y_ff;
   assign rsp_comp_z     = rsp_z_ff;
   assign rsp_saturated  = rsp_sat_ff;
   assign rsp_last_entry = rsp_last_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a beat that was not taken");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> ((rsp_row_ff == 2'd2) && (rsp_col_ff == 2'd2)))
      else $error("last entry flag on a result other than row 2 column 2");

endmodule

>>> rtl/core/biot_savart_field_hessian_unit.sv
// Top level of the Biot-Savart field Hessian unit: controller plus datapath.
// Depends on bsfh_pkg, bsfh_ctrl and bsfh_datapath.
//
//   Channel  Prefix  Direction  Beat
//   input    req_    in         one evaluation/quadrature point, tangent, last flag
//   result   rsp_    out        one (row, column) tensor entry, nine per last point
//
// An item goes through setup, 3 squares, 32 square root steps, four divisions
// in the shared divider, the inverse powers and cross product, then 9 rows on
// the shared multiplier and shifter. A coincident point skips the computation.
// A last point adds nine result beats, one per cycle while rsp_ready is high;
// a stalled output holds the sequencer.
// Reset is synchronous and clears the accumulators through their valid bits.
`timescale 1ns / 1ps

module biot_savart_field_hessian_unit #(
   parameter int COORD_FRAC_BITS = bsfh_pkg::DefaultFracBits
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic signed [31:0] req_curve_x,
   input  logic signed [31:0] req_curve_y,
   input  logic signed [31:0] req_curve_z,
   input  logic signed [31:0] req_tangent_x,
   input  logic signed [31:0] req_tangent_y,
   input  logic signed [31:0] req_tangent_z,
   input  logic               req_last_quad,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_row_index,
   output logic [1:0]         rsp_col_index,
   output logic signed [63:0] rsp_comp_x,
   output logic signed [63:0] rsp_comp_y,
   output logic signed [63:0] rsp_comp_z,
   output logic               rsp_saturated,
   output logic               rsp_last_entry
);
   import bsfh_pkg::*;

   cmd_type    cmd;
   status_type status;

   bsfh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bsfh_datapath #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .req_curve_x    (req_curve_x),
      .req_curve_y    (req_curve_y),
      .req_curve_z    (req_curve_z),
      .req_tangent_x  (req_tangent_x),
      .req_tangent_y  (req_tangent_y),
      .req_tangent_z  (req_tangent_z),
      .req_last_quad  (req_last_quad),
      .cmd            (cmd),
      .status         (status),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_row_index  (rsp_row_index),
      .rsp_col_index  (rsp_col_index),
      .rsp_comp_x     (rsp_comp_x),
      .rsp_comp_y     (rsp_comp_y),
      .rsp_comp_z     (rsp_comp_z),
      .rsp_saturated  (rsp_saturated),
      .rsp_last_entry (rsp_last_entry)
   );

endmodule
